/* rtl/varint_frame_deframer_top_defines.svh */
// Assertion macros shared by the deframer RTL.
`ifndef VARINT_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define VARINT_FRAME_DEFRAMER_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define VFD_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during rst.
`define VFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/vfd_pkg.sv */
// Types, codes and constants of the varint frame deframer.
package vfd_pkg;

  localparam int HEADER_BYTES_DEFAULT = 16;
  localparam int MAGIC_LEN            = 7;
  localparam int MAX_VARINT_BYTES     = 5;
  localparam int CFG_INDEX_W          = 1;
  localparam int CFG_DATA_W           = 32;
  // result queue depth in per-byte result pairs, power of two
  localparam int FIFO_DEPTH           = 2;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_KIND   = 3'd1,
    PH_TICK   = 3'd2,
    PH_SIZE   = 3'd3,
    PH_BODY   = 3'd4,
    PH_SKIP   = 3'd5,
    PH_HALT   = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    OT_HEADER = 3'd0,
    OT_BODY   = 3'd1,
    OT_END    = 3'd2,
    OT_STOP   = 3'd3,
    OT_ERROR  = 3'd4
  } out_code_t;

  typedef enum logic [1:0] {
    ERR_HEADER    = 2'd0,
    ERR_VARINT    = 2'd1,
    ERR_TRUNC_VAR = 2'd2,
    ERR_TRUNC_BODY = 2'd3
  } err_code_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_COMPRESSED_FLAG_MASK = 1'd0,
    REG_STOP_KIND            = 1'd1
  } cfg_reg_t;

  typedef struct packed {
    out_code_t   out_type;
    logic [31:0] frame_kind;
    logic        is_compressed;
    logic [31:0] frame_tick;
    logic [31:0] body_size;
    logic [7:0]  body_byte;
    logic        body_last;
    err_code_t   error_code;
  } result_t;

  // results caused by one input byte
  typedef struct packed {
    result_t r0;
    result_t r1;
    logic    two;
  } pair_t;

  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h50;
      3'd1:    b = 8'h42;
      3'd2:    b = 8'h44;
      3'd3:    b = 8'h45;
      3'd4:    b = 8'h4D;
      3'd5:    b = 8'h53;
      3'd6:    b = 8'h32;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* rtl/vfd_if.sv */
// Valid/ready channel interfaces for the deframer byte input and result output.
interface vfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface vfd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  out_type;
  logic [31:0] frame_kind;
  logic        is_compressed;
  logic [31:0] frame_tick;
  logic [31:0] body_size;
  logic [7:0]  body_byte;
  logic        body_last;
  logic [1:0]  error_code;
  logic        burst_last;

  modport source (
    output valid, output out_type, output frame_kind, output is_compressed,
    output frame_tick, output body_size, output body_byte, output body_last,
    output error_code, output burst_last, input ready
  );
  modport sink (
    input valid, input out_type, input frame_kind, input is_compressed,
    input frame_tick, input body_size, input body_byte, input body_last,
    input error_code, input burst_last, output ready
  );
endinterface

/* rtl/varint_frame_deframer_top.sv */
// Top level of the varint length-prefixed frame deframer.
// Usage:
//   in_ch carries one file byte per request with end_of_file on the final byte.
//   out_ch carries result requests: frame headers, body bytes, clean end,
//   stop frame or error; burst_last marks the last result of one input byte.
//   Configuration: cfg_wr_en with cfg_index 0 (compressed flag mask) or
//   1 (stop kind) and cfg_data, written only while the block is idle. The
//   block itself does not enforce it; the user must keep to this rule.
// Timing:
//   One input byte is accepted per cycle while the two-entry result queue
//   is not full; the parser computes its results combinationally and the
//   queue registers them before they reach out_ch. A byte that causes two
//   results (a body byte or a frame header's last byte, with end of file)
//   delivers them as two successive requests; the pair ends the stream.
// Reset: rst (synchronous) returns to the file header check and restores the
//   register defaults; queued results are dropped.
// Stall: when out_ch.ready is low the queue fills and in_ch.ready drops once
//   it holds two entries; no result is lost. After an error, clean end or
//   stop frame, input bytes are accepted and ignored until reset.
module varint_frame_deframer_top
  import vfd_pkg::*;
#(
  parameter int HEADER_BYTES = HEADER_BYTES_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  vfd_in_if.sink                 in_ch,
  vfd_out_if.source              out_ch
);

  logic  full;
  logic  accept;
  logic  push;
  pair_t wr_pair;

  assign in_ch.ready = !full;
  assign accept      = in_ch.valid && !full;

  vfd_parser #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .data_byte   (in_ch.data_byte),
    .end_of_file (in_ch.end_of_file),
    .push        (push),
    .wr_pair     (wr_pair)
  );

  vfd_result_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_pair (wr_pair),
    .full    (full),
    .out_ch  (out_ch)
  );

endmodule

/* rtl/vfd_result_fifo.sv */
// Result queue: stores per-byte result pairs and hands them out one request at a time.
`include "varint_frame_deframer_top_defines.svh"

module vfd_result_fifo
  import vfd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  pair_t     wr_pair,
  output logic      full,
  vfd_out_if.source out_ch
);

  localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  pair_t          mem [FIFO_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           sub;
  pair_t          cur;
  result_t        res;
  logic           fire;
  logic           pop_entry;

  assign full      = (count == CW'(FIFO_DEPTH));
  assign cur       = mem[rd_ptr];
  assign res       = sub ? cur.r1 : cur.r0;
  assign fire      = out_ch.valid && out_ch.ready;
  assign pop_entry = fire && (sub || !cur.two);

  assign out_ch.valid         = (count != '0);
  assign out_ch.out_type      = res.out_type;
  assign out_ch.frame_kind    = res.frame_kind;
  assign out_ch.is_compressed = res.is_compressed;
  assign out_ch.frame_tick    = res.frame_tick;
  assign out_ch.body_size     = res.body_size;
  assign out_ch.body_byte     = res.body_byte;
  assign out_ch.body_last     = res.body_last;
  assign out_ch.error_code    = res.error_code;
  assign out_ch.burst_last    = sub || !cur.two;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_pair;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      sub    <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop_entry) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      case ({push, pop_entry})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
      if (pop_entry) begin
        sub <= 1'b0;
      end else if (fire) begin
        sub <= 1'b1;
      end
    end
  end

  `VFD_ASSERT(a_no_push_full, push, !full, "push into full result queue")
  `VFD_ASSERT_NEXT(a_pair_second, fire && !pop_entry, sub && count != '0, "second result lost")
  `VFD_ASSERT(a_count_range, 1'b1, count <= CW'(FIFO_DEPTH), "queue count overflow")

endmodule

/* rtl/vfd_parser.sv */
// Byte parser: file header check, varint decode, frame and body tracking.
`include "varint_frame_deframer_top_defines.svh"

module vfd_parser
  import vfd_pkg::*;
#(
  parameter int HEADER_BYTES = HEADER_BYTES_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   accept,
  input  logic [7:0]             data_byte,
  input  logic                   end_of_file,
  output logic                   push,
  output pair_t                  wr_pair
);

  localparam int HCW = $clog2(HEADER_BYTES);

  logic [31:0]    compressed_flag_mask;
  logic [31:0]    stop_kind;

  phase_t         phase, phase_next;
  logic [HCW-1:0] header_count, header_count_next;
  logic [31:0]    varint_accum, varint_accum_next;
  logic [2:0]     varint_index, varint_index_next;
  logic [31:0]    held_kind, held_kind_next;
  logic [31:0]    held_tick, held_tick_next;
  logic [31:0]    body_remaining, body_remaining_next;
  logic           held_compressed, held_compressed_next;

  logic           hdr_bad;
  logic           hdr_last;
  logic [5:0]     shamt;
  logic [31:0]    accum_new;
  logic           cont;
  logic           too_long;
  logic           is_stop;
  logic           v_zero;
  logic [31:0]    rem_dec;
  logic           rem_zero;

  result_t        r0, r1;
  logic [1:0]     n;

  function automatic result_t mk_result(
    input out_code_t   code,
    input logic [31:0] kind,
    input logic        comp,
    input logic [31:0] tick,
    input logic [31:0] size,
    input logic [7:0]  b,
    input logic        last,
    input err_code_t   err
  );
    result_t r;
    r.out_type      = code;
    r.frame_kind    = kind;
    r.is_compressed = comp;
    r.frame_tick    = tick;
    r.body_size     = size;
    r.body_byte     = b;
    r.body_last     = last;
    r.error_code    = err;
    return r;
  endfunction

  function automatic result_t mk_flag(input out_code_t code, input err_code_t err);
    return mk_result(code, '0, 1'b0, '0, '0, '0, 1'b0, err);
  endfunction

  always_comb begin
    hdr_bad   = (header_count < HCW'(MAGIC_LEN))
                && (data_byte != magic_byte(header_count[2:0]));
    hdr_last  = (header_count == HCW'(HEADER_BYTES - 1));
    shamt     = 6'(varint_index) * 6'd7;
    accum_new = varint_accum | (32'(data_byte[6:0]) << shamt);
    cont      = data_byte[7];
    too_long  = (varint_index >= 3'(MAX_VARINT_BYTES - 1));
    is_stop   = (held_kind == stop_kind);
    v_zero    = (accum_new == '0);
    rem_dec   = body_remaining - 32'd1;
    rem_zero  = (rem_dec == '0);
  end

  // next state
  always_comb begin
    phase_next           = phase;
    header_count_next    = header_count;
    varint_accum_next    = varint_accum;
    varint_index_next    = varint_index;
    held_kind_next       = held_kind;
    held_tick_next       = held_tick;
    body_remaining_next  = body_remaining;
    held_compressed_next = held_compressed;
    if (accept) begin
      unique case (phase) inside
        PH_HEADER: begin
          if (hdr_bad) begin
            phase_next = PH_HALT;
          end else if (hdr_last) begin
            varint_accum_next = '0;
            varint_index_next = '0;
            phase_next        = end_of_file ? PH_HALT : PH_KIND;
          end else begin
            header_count_next = header_count + HCW'(1);
            if (end_of_file) begin
              phase_next = PH_HALT;
            end
          end
        end
        PH_KIND, PH_TICK, PH_SIZE: begin
          if (cont) begin
            varint_accum_next = accum_new;
            varint_index_next = varint_index + 3'd1;
            if (too_long || end_of_file) begin
              phase_next = PH_HALT;
            end
          end else begin
            varint_accum_next = '0;
            varint_index_next = '0;
            if (phase == PH_KIND) begin
              held_compressed_next = |(accum_new & compressed_flag_mask);
              held_kind_next       = accum_new & ~compressed_flag_mask;
              phase_next           = end_of_file ? PH_HALT : PH_TICK;
            end else if (phase == PH_TICK) begin
              held_tick_next = accum_new;
              phase_next     = end_of_file ? PH_HALT : PH_SIZE;
            end else begin
              body_remaining_next = accum_new;
              if (v_zero || end_of_file) begin
                phase_next = is_stop || end_of_file ? PH_HALT : PH_KIND;
              end else begin
                phase_next = is_stop ? PH_SKIP : PH_BODY;
              end
            end
          end
        end
        PH_BODY: begin
          body_remaining_next = rem_dec;
          if (end_of_file) begin
            phase_next = PH_HALT;
          end else if (rem_zero) begin
            phase_next = PH_KIND;
          end
        end
        PH_SKIP: begin
          body_remaining_next = rem_dec;
          if (rem_zero || end_of_file) begin
            phase_next = PH_HALT;
          end
        end
        PH_HALT: begin
          phase_next = PH_HALT;
        end
        default: begin
          phase_next = PH_HALT;
        end
      endcase
    end
  end

  // results
  always_comb begin
    r0 = '0;
    r1 = '0;
    n  = 2'd0;
    if (accept) begin
      unique case (phase) inside
        PH_HEADER: begin
          if (hdr_bad) begin
            r0 = mk_flag(OT_ERROR, ERR_HEADER);
            n  = 2'd1;
          end else if (end_of_file) begin
            r0 = hdr_last ? mk_flag(OT_END, ERR_HEADER) : mk_flag(OT_ERROR, ERR_HEADER);
            n  = 2'd1;
          end
        end
        PH_KIND, PH_TICK, PH_SIZE: begin
          if (cont) begin
            if (too_long) begin
              r0 = mk_flag(OT_ERROR, ERR_VARINT);
              n  = 2'd1;
            end else if (end_of_file) begin
              r0 = mk_flag(OT_ERROR, ERR_TRUNC_VAR);
              n  = 2'd1;
            end
          end else if (phase != PH_SIZE) begin
            if (end_of_file) begin
              r0 = mk_flag(OT_ERROR, ERR_TRUNC_VAR);
              n  = 2'd1;
            end
          end else if (is_stop) begin
            if (v_zero) begin
              r0 = mk_result(OT_STOP, held_kind, held_compressed, held_tick, '0, '0,
                             1'b0, ERR_HEADER);
              n  = 2'd1;
            end else if (end_of_file) begin
              r0 = mk_flag(OT_ERROR, ERR_TRUNC_BODY);
              n  = 2'd1;
            end
          end else begin
            r0 = mk_result(OT_HEADER, held_kind, held_compressed, held_tick, accum_new,
                           '0, v_zero, ERR_HEADER);
            n  = 2'd1;
            if (end_of_file) begin
              r1 = v_zero ? mk_flag(OT_END, ERR_HEADER) : mk_flag(OT_ERROR, ERR_TRUNC_BODY);
              n  = 2'd2;
            end
          end
        end
        PH_BODY: begin
          r0 = mk_result(OT_BODY, held_kind, held_compressed, held_tick, '0, data_byte,
                         rem_zero, ERR_HEADER);
          n  = 2'd1;
          if (end_of_file) begin
            r1 = rem_zero ? mk_flag(OT_END, ERR_HEADER) : mk_flag(OT_ERROR, ERR_TRUNC_BODY);
            n  = 2'd2;
          end
        end
        PH_SKIP: begin
          if (rem_zero) begin
            r0 = mk_result(OT_STOP, held_kind, held_compressed, held_tick, '0, '0,
                           1'b0, ERR_HEADER);
            n  = 2'd1;
          end else if (end_of_file) begin
            r0 = mk_flag(OT_ERROR, ERR_TRUNC_BODY);
            n  = 2'd1;
          end
        end
        PH_HALT: begin
          n = 2'd0;
        end
        default: begin
          n = 2'd0;
        end
      endcase
    end
  end

  assign push        = (n != 2'd0);
  assign wr_pair.r0  = r0;
  assign wr_pair.r1  = r1;
  assign wr_pair.two = (n == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      compressed_flag_mask <= 32'd64;
      stop_kind            <= 32'd0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_COMPRESSED_FLAG_MASK: compressed_flag_mask <= cfg_data;
        REG_STOP_KIND:            stop_kind            <= cfg_data;
        default:                  stop_kind            <= stop_kind;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      header_count    <= '0;
      varint_accum    <= '0;
      varint_index    <= '0;
      held_kind       <= '0;
      held_tick       <= '0;
      body_remaining  <= '0;
      held_compressed <= 1'b0;
    end else begin
      phase           <= phase_next;
      header_count    <= header_count_next;
      varint_accum    <= varint_accum_next;
      varint_index    <= varint_index_next;
      held_kind       <= held_kind_next;
      held_tick       <= held_tick_next;
      body_remaining  <= body_remaining_next;
      held_compressed <= held_compressed_next;
    end
  end

  `VFD_ASSERT_NEXT(a_halt_sticky, phase == PH_HALT, phase == PH_HALT, "left halt state")
  `VFD_ASSERT_NEXT(a_pair_halts, accept && n == 2'd2, phase == PH_HALT, "two results without halt")
  `VFD_ASSERT(a_hdr_range, phase == PH_HEADER, header_count <= HCW'(HEADER_BYTES - 1), "header count")

endmodule

/* test/tb_top.sv */
// Testbench for the varint frame deframer: file streams with random handshakes, checked by a scoreboard.
module tb_top
  import vfd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          HDR_LEN     = HEADER_BYTES_DEFAULT;
  localparam logic [31:0] MASK_RESET  = 32'd64;
  localparam logic [55:0] MAGIC_WORD  = "PBDEMS2";
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned ITEM_TARGET = 1500;
  // error_code reads zero on every non-error result
  localparam err_code_t   NO_ERR      = ERR_HEADER;

  typedef struct packed {
    result_t res;
    logic    burst_last;
  } deframe_out_t;

  // how the file ends; the block halts there and ignores the rest
  typedef enum int {
    END_BAD_MAGIC, END_SHORT_HEADER, END_AT_HEADER,
    END_AFTER_BODY, END_AFTER_EMPTY, STOP_EMPTY, STOP_BODY, STOP_CUT_BODY,
    STOP_CUT_SIZE, VARINT_LONG, VARINT_CUT, VARINT_MISSING, FRAME_CUT_SIZE,
    FRAME_CUT_BODY
  } ending_t;

  class deframe_scoreboard;
    logic [31:0]  flag_mask, stop_val;
    phase_t       ph;
    int unsigned  hdr_cnt, vidx;
    logic [31:0]  accum, kind_q, tick_q, remain;
    logic         comp_q;
    deframe_out_t burst[$];
    deframe_out_t expected_q[$];
    int           errors;

    function new();
      errors = 0;
      flag_mask = MASK_RESET;
      stop_val = '0;
      ph = PH_HEADER;
      hdr_cnt = 0;
      vidx = 0;
      accum = '0;
      kind_q = '0;
      tick_q = '0;
      remain = '0;
      comp_q = 1'b0;
    endfunction

    function logic [7:0] magic_at(int unsigned i);
      return MAGIC_WORD[8 * (MAGIC_LEN - 1 - i) +: 8];
    endfunction

    function void set_config(logic [31:0] mask, logic [31:0] stop_kind);
      flag_mask = mask;
      stop_val = stop_kind;
    endfunction

    function void add(out_code_t code, logic [31:0] kind, logic comp, logic [31:0] tick,
                      logic [31:0] size, logic [7:0] data, logic last, err_code_t err);
      deframe_out_t r;
      r.res.out_type      = code;
      r.res.frame_kind    = kind;
      r.res.is_compressed = comp;
      r.res.frame_tick    = tick;
      r.res.body_size     = size;
      r.res.body_byte     = data;
      r.res.body_last     = last;
      r.res.error_code    = err;
      r.burst_last        = 1'b0;
      burst.push_back(r);
    endfunction

    function void halt_with(out_code_t code, err_code_t err);
      ph = PH_HALT;
      add(code, '0, 1'b0, '0, '0, '0, 1'b0, err);
    endfunction

    function void stop_seen();
      ph = PH_HALT;
      add(OT_STOP, kind_q, comp_q, tick_q, '0, '0, 1'b0, NO_ERR);
    endfunction

    function void close_frame(logic [31:0] size, logic eof);
      remain = size;
      if (kind_q == stop_val) begin
        if (size == 0) stop_seen();
        else if (eof) halt_with(OT_ERROR, ERR_TRUNC_BODY);
        else ph = PH_SKIP;
      end else begin
        add(OT_HEADER, kind_q, comp_q, tick_q, size, '0, size == 0, NO_ERR);
        if (size == 0) begin
          ph = PH_KIND;
          if (eof) halt_with(OT_END, NO_ERR);
        end else begin
          ph = PH_BODY;
          if (eof) halt_with(OT_ERROR, ERR_TRUNC_BODY);
        end
      end
    endfunction

    function void note_byte(logic [7:0] b, logic eof);
      logic [31:0] v;
      int unsigned sh;
      deframe_out_t r;
      burst.delete();
      case (ph)
        PH_HEADER: begin
          if (hdr_cnt < MAGIC_LEN && b != magic_at(hdr_cnt)) begin
            halt_with(OT_ERROR, ERR_HEADER);
          end else if (hdr_cnt + 1 >= HDR_LEN) begin
            ph = PH_KIND;
            accum = '0;
            vidx = 0;
            if (eof) halt_with(OT_END, NO_ERR);
          end else begin
            hdr_cnt++;
            if (eof) halt_with(OT_ERROR, ERR_HEADER);
          end
        end
        PH_KIND, PH_TICK, PH_SIZE: begin
          sh = 7 * vidx;
          if (sh < 32) accum |= {25'd0, b[6:0]} << sh;
          if (b[7]) begin
            vidx++;
            if (vidx >= MAX_VARINT_BYTES) halt_with(OT_ERROR, ERR_VARINT);
            else if (eof) halt_with(OT_ERROR, ERR_TRUNC_VAR);
          end else begin
            v = accum;
            accum = '0;
            vidx = 0;
            if (ph == PH_KIND) begin
              comp_q = |(v & flag_mask);
              kind_q = v & ~flag_mask;
              ph = PH_TICK;
              if (eof) halt_with(OT_ERROR, ERR_TRUNC_VAR);
            end else if (ph == PH_TICK) begin
              tick_q = v;
              ph = PH_SIZE;
              if (eof) halt_with(OT_ERROR, ERR_TRUNC_VAR);
            end else begin
              close_frame(v, eof);
            end
          end
        end
        PH_BODY: begin
          remain--;
          add(OT_BODY, kind_q, comp_q, tick_q, '0, b, remain == 0, NO_ERR);
          if (remain == 0) begin
            ph = PH_KIND;
            if (eof) halt_with(OT_END, NO_ERR);
          end else if (eof) begin
            halt_with(OT_ERROR, ERR_TRUNC_BODY);
          end
        end
        PH_SKIP: begin
          remain--;
          if (remain == 0) stop_seen();
          else if (eof) halt_with(OT_ERROR, ERR_TRUNC_BODY);
        end
        default: ;
      endcase
      foreach (burst[i]) begin
        r = burst[i];
        r.burst_last = (i == burst.size() - 1);
        expected_q.push_back(r);
      end
    endfunction

    function void diff(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %h, got %h", $time, field, want, got);
      end
    endfunction

    function void check_result(deframe_out_t got);
      deframe_out_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, out_type expected none, got %0d",
                 $time, got.res.out_type);
        return;
      end
      want = expected_q.pop_front();
      diff("out_type", want.res.out_type, got.res.out_type);
      diff("frame_kind", want.res.frame_kind, got.res.frame_kind);
      diff("is_compressed", want.res.is_compressed, got.res.is_compressed);
      diff("frame_tick", want.res.frame_tick, got.res.frame_tick);
      diff("body_size", want.res.body_size, got.res.body_size);
      diff("body_byte", want.res.body_byte, got.res.body_byte);
      diff("body_last", want.res.body_last, got.res.body_last);
      diff("error_code", want.res.error_code, got.res.error_code);
      diff("burst_last", want.burst_last, got.burst_last);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  vfd_in_if               in_ch ();
  vfd_out_if              out_ch ();

  deframe_scoreboard sb = new();
  deframe_out_t      seen;
  int unsigned       cycle_count = 0;
  int unsigned       bytes_sent = 0;
  bit                in_calm = 1'b0;
  bit                out_calm = 1'b0;

  varint_frame_deframer_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) sb.note_byte(in_ch.data_byte, in_ch.end_of_file);
    if (!rst && out_ch.valid && out_ch.ready) begin
      seen.res.out_type      = out_code_t'(out_ch.out_type);
      seen.res.frame_kind    = out_ch.frame_kind;
      seen.res.is_compressed = out_ch.is_compressed;
      seen.res.frame_tick    = out_ch.frame_tick;
      seen.res.body_size     = out_ch.body_size;
      seen.res.body_byte     = out_ch.body_byte;
      seen.res.body_last     = out_ch.body_last;
      seen.res.error_code    = err_code_t'(out_ch.error_code);
      seen.burst_last        = out_ch.burst_last;
      sb.check_result(seen);
    end
  end

  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = out_calm ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(0, 127);
      1:       return $urandom_range(0, 20000);
      2:       return $urandom;
      3:       return 32'hFFFF_FFFF;
      default: return 32'd1 << $urandom_range(0, 31);
    endcase
  endfunction

  // any kind that does not end the stream under the current settings
  function automatic logic [31:0] normal_kind();
    logic [31:0] raw;
    do begin
      raw = pick_word();
      if ($urandom_range(0, 1)) raw |= sb.flag_mask & $urandom;
    end while ((raw & ~sb.flag_mask) == sb.stop_val);
    return raw;
  endfunction

  function automatic logic [7:0] hdr_byte(int unsigned i);
    return (i < MAGIC_LEN) ? sb.magic_at(i) : 8'($urandom);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eof);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.end_of_file <= eof;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_config(input logic [31:0] mask, input logic [31:0] stop_kind);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_COMPRESSED_FLAG_MASK;
    cfg_data <= mask;
    @(posedge clk);
    cfg_index <= REG_STOP_KIND;
    cfg_data <= stop_kind;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_config(mask, stop_kind);
  endtask

  // LEB128, sometimes padded with empty groups; the fifth byte carries junk above bit 31
  task automatic send_varint(input logic [31:0] v, input logic eof);
    int n, len;
    logic [7:0] b;
    n = 1;
    while (n < 5 && (v >> (7 * n)) != 0) n++;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(n, 5) : n;
    for (int i = 0; i < len; i++) begin
      if (i == 4) begin
        b[6:4] = 3'($urandom_range(0, 7));
        b[3:0] = v[31:28];
      end else begin
        b[6:0] = 7'(v >> (7 * i));
      end
      b[7] = (i < len - 1);
      send_byte(b, eof && (i == len - 1));
    end
  endtask

  task automatic send_cont(input int count, input logic eof);
    for (int i = 0; i < count; i++) send_byte({1'b1, 7'($urandom)}, eof && (i == count - 1));
  endtask

  task automatic send_head(input logic [31:0] kind, input logic [31:0] tick,
                           input logic [31:0] size, input logic eof);
    send_varint(kind, 1'b0);
    send_varint(tick, 1'b0);
    send_varint(size, eof);
  endtask

  task automatic send_frame(input logic [31:0] kind, input logic [31:0] tick,
                            input logic [31:0] size, input logic eof);
    send_head(kind, tick, size, eof && size == 0);
    for (int i = 0; i < size; i++) send_byte(8'($urandom), eof && (i == size - 1));
  endtask

  task automatic send_body(input int count);
    for (int i = 0; i < count; i++) send_byte(8'($urandom), i == count - 1);
  endtask

  task automatic send_random_frame();
    logic [31:0] size;
    size = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
    send_frame(normal_kind(), pick_word(), size, 1'b0);
  endtask

  // the stop kind must be reachable with the mask bits cleared
  task automatic stop_kind_raw(output logic [31:0] raw);
    if ((sb.stop_val & sb.flag_mask) != 0)
      apply_config(sb.flag_mask, sb.stop_val & ~sb.flag_mask);
    raw = sb.stop_val | ($urandom & sb.flag_mask);
  endtask

  task automatic finish_file(input ending_t how);
    int pos, cut;
    logic [31:0] raw, size;
    pos = $urandom_range(0, 2);
    size = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom_range(2, 9);
    cut = $urandom_range(1, (size > 9) ? 9 : size - 1);
    case (how)
      END_BAD_MAGIC: begin
        pos = $urandom_range(0, MAGIC_LEN - 1);
        for (int i = 0; i < pos; i++) send_byte(hdr_byte(i), 1'b0);
        send_byte(sb.magic_at(pos) ^ (8'd1 << $urandom_range(0, 7)), 1'($urandom));
      end
      END_SHORT_HEADER: begin
        pos = $urandom_range(0, HDR_LEN - 2);
        for (int i = 0; i <= pos; i++) send_byte(hdr_byte(i), i == pos);
      end
      END_AT_HEADER: begin
        for (int i = 0; i < HDR_LEN; i++) send_byte(hdr_byte(i), i == HDR_LEN - 1);
      end
      END_AFTER_BODY: send_frame(normal_kind(), pick_word(), $urandom_range(1, 8), 1'b1);
      END_AFTER_EMPTY: send_frame(normal_kind(), pick_word(), '0, 1'b1);
      STOP_EMPTY: begin
        stop_kind_raw(raw);
        send_head(raw, pick_word(), '0, 1'($urandom));
      end
      STOP_BODY: begin
        stop_kind_raw(raw);
        send_frame(raw, pick_word(), $urandom_range(1, 8), 1'($urandom));
      end
      STOP_CUT_BODY: begin
        stop_kind_raw(raw);
        send_head(raw, pick_word(), size, 1'b0);
        send_body(cut);
      end
      STOP_CUT_SIZE: begin
        stop_kind_raw(raw);
        send_head(raw, pick_word(), size, 1'b1);
      end
      VARINT_LONG: begin
        if (pos >= 1) send_varint(normal_kind(), 1'b0);
        if (pos >= 2) send_varint(pick_word(), 1'b0);
        send_cont(MAX_VARINT_BYTES - 1, 1'b0);
        send_byte({1'b1, 7'($urandom)}, 1'($urandom));
      end
      VARINT_CUT: begin
        if (pos >= 1) send_varint(normal_kind(), 1'b0);
        if (pos >= 2) send_varint(pick_word(), 1'b0);
        send_cont($urandom_range(1, MAX_VARINT_BYTES - 1), 1'b1);
      end
      VARINT_MISSING: begin
        if (pos == 0) begin
          send_varint(normal_kind(), 1'b1);
        end else begin
          send_varint(normal_kind(), 1'b0);
          send_varint(pick_word(), 1'b1);
        end
      end
      FRAME_CUT_SIZE: send_head(normal_kind(), pick_word(), size, 1'b1);
      default: begin
        send_head(normal_kind(), pick_word(), size, 1'b0);
        send_body(cut);
      end
    endcase
  endtask

  initial begin : stimulus
    logic [31:0] mask, stop_kind;
    int unsigned budget;
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_COMPRESSED_FLAG_MASK;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.end_of_file <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    apply_config(MASK_RESET, '0);

    if ($urandom_range(0, 15) == 0) begin
      finish_file(ending_t'($urandom_range(END_BAD_MAGIC, END_AT_HEADER)));
    end else begin
      for (int i = 0; i < HDR_LEN; i++) send_byte(hdr_byte(i), 1'b0);
      // compressed kind, tick all ones in five bytes, body extremes, then an empty body
      send_varint(32'h41, 1'b0);
      send_varint(32'hFFFF_FFFF, 1'b0);
      send_varint(32'd2, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_head(32'd2, '0, '0, 1'b0);
      settle();

      for (int p = 0; p < 8; p++) begin
        case (p)
          0: begin mask = '0;           stop_kind = 32'hFFFF_FFFF; end
          1: begin mask = 32'hFFFF_FFFF; stop_kind = 32'd1;        end
          2: begin mask = 32'h8000_0000; stop_kind = '0;           end
          3: begin mask = MASK_RESET;    stop_kind = 32'd3;        end
          default: begin
            mask = pick_word();
            stop_kind = pick_word();
            if (mask == 32'hFFFF_FFFF && stop_kind == 0) stop_kind = 32'd1;
          end
        endcase
        apply_config(mask, stop_kind);
        in_calm = ($urandom_range(0, 3) == 0);
        out_calm = ($urandom_range(0, 3) == 0);
        budget = bytes_sent + 185;
        while (bytes_sent < budget) send_random_frame();
        settle();
      end
      finish_file(ending_t'($urandom_range(END_AFTER_BODY, FRAME_CUT_BODY)));
    end
    settle();

    // the block has halted; these are accepted and dropped
    repeat ($urandom_range(2, 6)) send_byte(8'($urandom), 1'($urandom));
    while (bytes_sent < ITEM_TARGET) send_byte(8'($urandom), 1'($urandom));
    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

/* filelist.f */
+incdir+rtl
rtl/vfd_pkg.sv
rtl/vfd_if.sv
rtl/vfd_result_fifo.sv
rtl/vfd_parser.sv
rtl/varint_frame_deframer_top.sv
test/tb_top.sv
